[hw/rtl/irw_pkg.sv]
// Shared types and constants for the in-flight retransmit window.
package irw_pkg;

  localparam int SLOTS = 16;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);

  localparam logic [1:0] REQ_TRACK = 2'd0;
  localparam logic [1:0] REQ_ACK = 2'd1;
  localparam logic [1:0] REQ_SCAN = 2'd2;
  localparam logic [1:0] REQ_CLEAR = 2'd3;

  localparam logic [2:0] KIND_TRACK = 3'd0;
  localparam logic [2:0] KIND_ACK = 3'd1;
  localparam logic [2:0] KIND_RESEND = 3'd2;
  localparam logic [2:0] KIND_SCAN = 3'd3;
  localparam logic [2:0] KIND_CLEAR = 3'd4;

  localparam logic REG_MAX_RETRIES = 1'b0;
  localparam logic REG_INTERVAL = 1'b1;

  typedef struct packed {
    logic [1:0] req_type;
    logic [31:0] request_id;
    logic [15:0] record_count;
    logic [31:0] buffer_offset;
    logic [47:0] now_ms;
  } req_t;

  typedef struct packed {
    logic [2:0] result_kind;
    logic accepted;
    logic [15:0] acked_records;
    logic [31:0] resend_offset;
    logic [4:0] resend_count;
    logic [4:0] inflight_slots;
    logic [19:0] lost_records;
    logic [31:0] resend_total_out;
    logic last;
  } rsp_t;

  // One slot record as held in the slot memory.
  typedef struct packed {
    logic [15:0] records;
    logic [31:0] offset;
    logic [47:0] sent_time;
    logic [7:0] retries;
  } slot_t;

endpackage

[hw/rtl/irw_slot_ram.sv]
// Slot record memory: one write port, one registered read port.
module irw_slot_ram (
  input  logic                        clk,
  input  logic                        we,
  input  logic [irw_pkg::SLOT_W-1:0]  waddr,
  input  irw_pkg::slot_t              wdata,
  input  logic [irw_pkg::SLOT_W-1:0]  raddr,
  output irw_pkg::slot_t              rdata
);

  irw_pkg::slot_t mem [irw_pkg::SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/inflight_retransmit_window_core.sv]
// Top level of the in-flight retransmit window.
//
// Usage:
//   Requests enter on in_valid/in_ready as one req_t transaction. Results
//   leave on out_valid/out_ready as rsp_t transactions, with last set on the
//   final result of each request. Configuration is written on cfg_we with
//   cfg_index (0 max_retries, 1 retry_interval_ms) and cfg_data; the user
//   must write it only while the block is idle; the block does not enforce it.
//   Slot ids and record counts sit in registers, so the free-slot and id-match
//   searches are one priority encode. Occupancy and lost records are kept as
//   running counts. The rest of each slot lives in a registered-read memory;
//   the due test ignores whatever a free slot reads back.
//   Flow: a track, ack or clear result is registered from the execute state
//   once the result register is free, and the block then returns to idle, so
//   a new request is taken only after the last result is registered. A scan
//   walks the slots in turn, each through a read state and then a check state
//   that compares and writes back; after the last slot the finish state
//   registers the closing result and the block returns to idle.
//   Reset clears every busy flag, the counts and the resend total and loads the
//   register defaults; no memory sweep is needed. When out_ready is low the
//   result register holds and the sequencer waits; nothing is dropped.
module inflight_retransmit_window_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  irw_pkg::req_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output irw_pkg::rsp_t   out_data,
  input  logic            cfg_we,
  input  logic [0:0]      cfg_index,
  input  logic [31:0]     cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_EXEC, ST_READ, ST_CHECK, ST_FINISH
  } state_t;

  state_t state;
  irw_pkg::req_t req;
  logic [7:0] max_retries;
  logic [31:0] retry_interval_ms;
  logic [31:0] resend_total;
  logic [31:0] ids [irw_pkg::SLOTS];
  logic [irw_pkg::SLOTS-1:0] busy;
  logic [15:0] recs [irw_pkg::SLOTS];
  logic [irw_pkg::SLOT_W-1:0] idx;
  logic [irw_pkg::CNT_W-1:0] scan_cnt;
  logic [4:0] occ;
  logic [19:0] lost;

  // Slot memory port signals.
  logic ram_we;
  logic [irw_pkg::SLOT_W-1:0] ram_waddr, ram_raddr;
  irw_pkg::slot_t ram_wdata, ram_rdata;

  irw_slot_ram u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  // Lowest free slot and lowest id match.
  logic free_hit, id_hit;
  logic [irw_pkg::SLOT_W-1:0] free_idx, id_idx;
  always_comb begin
    free_hit = 1'b0;
    id_hit = 1'b0;
    free_idx = '0;
    id_idx = '0;
    for (int j = irw_pkg::SLOTS - 1; j >= 0; j--) begin
      if (!busy[j]) begin
        free_hit = 1'b1;
        free_idx = irw_pkg::SLOT_W'(j);
      end
      if (busy[j] && ids[j] == req.request_id) begin
        id_hit = 1'b1;
        id_idx = irw_pkg::SLOT_W'(j);
      end
    end
  end

  logic ack_hit;
  assign ack_hit = (req.request_id != '0) && id_hit;

  // Due test on the slot just read.
  logic [47:0] age;
  logic due;
  always_comb begin
    age = req.now_ms - ram_rdata.sent_time;
    due = busy[idx] && (ram_rdata.retries < max_retries) &&
          (req.now_ms >= ram_rdata.sent_time) && (age >= 48'(retry_interval_ms));
  end

  logic last_slot;
  assign last_slot = (32'(idx) == 32'(irw_pkg::SLOTS - 1));

  // The result register can take a new result this cycle.
  logic out_free;
  assign out_free = !out_valid || out_ready;

  assign in_ready = (state == ST_IDLE);
  assign ram_raddr = idx;

  // Next result, next counts and the slot memory write for this step.
  logic load_out;
  irw_pkg::rsp_t out_next;
  logic [4:0] occ_next;
  logic [19:0] lost_next;
  always_comb begin
    load_out = 1'b0;
    out_next = '0;
    out_next.resend_total_out = resend_total;
    occ_next = occ;
    lost_next = lost;
    ram_we = 1'b0;
    ram_waddr = idx;
    ram_wdata = ram_rdata;
    case (state)
      ST_EXEC: begin
        load_out = out_free;
        out_next.last = 1'b1;
        case (req.req_type)
          irw_pkg::REQ_TRACK: begin
            out_next.result_kind = irw_pkg::KIND_TRACK;
            out_next.accepted = free_hit;
            if (free_hit && req.request_id != '0) begin
              occ_next = occ + 5'd1;
              lost_next = lost + 20'(req.record_count);
            end
            ram_we = out_free && free_hit;
            ram_waddr = free_idx;
            ram_wdata.records = req.record_count;
            ram_wdata.offset = req.buffer_offset;
            ram_wdata.sent_time = req.now_ms;
            ram_wdata.retries = '0;
          end
          irw_pkg::REQ_ACK: begin
            out_next.result_kind = irw_pkg::KIND_ACK;
            if (ack_hit) begin
              out_next.acked_records = recs[id_idx];
              occ_next = occ - 5'd1;
              lost_next = lost - 20'(recs[id_idx]);
            end
          end
          irw_pkg::REQ_CLEAR: begin
            out_next.result_kind = irw_pkg::KIND_CLEAR;
            occ_next = '0;
            lost_next = '0;
          end
          default: ;
        endcase
      end
      ST_CHECK: begin
        if (due) begin
          // Restamp and bump the slot being resent.
          load_out = out_free;
          ram_we = out_free;
          ram_wdata.sent_time = req.now_ms;
          ram_wdata.retries = ram_rdata.retries + 8'd1;
          out_next.result_kind = irw_pkg::KIND_RESEND;
          out_next.resend_offset = ram_rdata.offset;
          out_next.resend_total_out = resend_total + 32'd1;
        end
      end
      ST_FINISH: begin
        load_out = out_free;
        out_next.result_kind = irw_pkg::KIND_SCAN;
        out_next.resend_count = 5'(scan_cnt);
        out_next.last = 1'b1;
      end
      default: ;
    endcase
    out_next.inflight_slots = occ_next;
    out_next.lost_records = lost_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      busy <= '0;
      out_valid <= 1'b0;
      resend_total <= '0;
      max_retries <= 8'd3;
      retry_interval_ms <= 32'd1000;
      idx <= '0;
      scan_cnt <= '0;
      occ <= '0;
      lost <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          irw_pkg::REG_MAX_RETRIES: max_retries <= cfg_data[7:0];
          irw_pkg::REG_INTERVAL: retry_interval_ms <= cfg_data;
          default: ;
        endcase
      end
      // Hold a result until it is taken, load the next one when free.
      out_valid <= load_out || (out_valid && !out_ready);
      if (load_out) begin
        out_data <= out_next;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid && in_ready) begin
            req <= in_data;
            idx <= '0;
            scan_cnt <= '0;
            state <= (in_data.req_type == irw_pkg::REQ_SCAN) ? ST_READ : ST_EXEC;
          end
        end
        ST_EXEC: begin
          // Commit the slot update together with its result.
          if (load_out) begin
            occ <= occ_next;
            lost <= lost_next;
            case (req.req_type)
              irw_pkg::REQ_TRACK: begin
                if (free_hit) begin
                  ids[free_idx] <= req.request_id;
                  recs[free_idx] <= req.record_count;
                  busy[free_idx] <= (req.request_id != '0);
                end
              end
              irw_pkg::REQ_ACK: begin
                if (ack_hit) begin
                  busy[id_idx] <= 1'b0;
                end
              end
              irw_pkg::REQ_CLEAR: busy <= '0;
              default: ;
            endcase
            state <= ST_IDLE;
          end
        end
        ST_READ: state <= ST_CHECK;
        ST_CHECK: begin
          // Wait on a due slot until its result fits, then advance.
          if (!due || load_out) begin
            if (due) begin
              resend_total <= resend_total + 32'd1;
              scan_cnt <= scan_cnt + 1'b1;
            end
            if (last_slot) begin
              state <= ST_FINISH;
            end else begin
              idx <= idx + 1'b1;
              state <= ST_READ;
            end
          end
        end
        ST_FINISH: begin
          if (load_out) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !in_ready) else $error("accept while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("result dropped or changed");
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    32'(scan_cnt) <= irw_pkg::SLOTS) else $error("scan count overflow");
  a_occ_match: assert property (@(posedge clk) disable iff (rst)
    32'(occ) == $countones(busy)) else $error("occupancy count off");

endmodule
